// ----- hdl/sorted_list_insert_remove_defines.svh -----
// Assertion macros shared by the checker of the sorted list block.
`ifndef SORTED_LIST_INSERT_REMOVE_DEFINES_SVH
`define SORTED_LIST_INSERT_REMOVE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SLRI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SLRI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/slri_pkg.sv -----
// Package with the types and constants of the sorted list block.
package slri_pkg;

  localparam int SLRI_CAPACITY = 16;
  localparam int VALUE_W       = 32;
  localparam int COUNT_W       = 5;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // Operation broadcast to every cell of the row.
  typedef struct packed {
    logic                      ins_en;
    logic                      rem_en;
    logic signed [VALUE_W-1:0] value;
  } slri_op_t;

endpackage

// ----- hdl/slri_cell.sv -----
// One compare-and-shift cell of the sorted row.
module slri_cell import slri_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  slri_op_t                  op,
  input  logic                      left_lt,
  input  logic                      left_valid,
  input  logic signed [VALUE_W-1:0] left_val,
  input  logic                      right_valid,
  input  logic signed [VALUE_W-1:0] right_val,
  input  logic                      hit_in,
  output logic                      lt,
  output logic                      stored_valid,
  output logic signed [VALUE_W-1:0] stored_val,
  output logic                      hit_out
);

  // Entries are sorted, so the cells holding smaller values form a prefix.
  assign lt      = stored_valid && (stored_val < op.value);
  // The hit chain goes high at the first equal entry and stays high to the right.
  assign hit_out = hit_in || (stored_valid && (stored_val == op.value));

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_valid <= 1'b0;
    end else if (op.ins_en) begin
      stored_valid <= stored_valid || left_valid;
    end else if (op.rem_en && hit_out) begin
      stored_valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op.ins_en && !lt) begin
      stored_val <= left_lt ? op.value : left_val;
    end else if (op.rem_en && hit_out) begin
      stored_val <= right_val;
    end
  end

endmodule

// ----- hdl/sorted_list_insert_remove.sv -----
// Top level of the sorted list block: a row of compare-and-shift cells.
//
// The block keeps up to CAPACITY signed 32-bit values in ascending order.
// Each input request carries an action (insert or remove) and a value. An
// insert places the value before any equal values already held and fails
// when the list is full; a remove takes out the first equal value and fails
// when none is held. Every request gives exactly one result: ok, the count
// after the operation (low 5 bits) and an empty flag.
// Both channels use valid and stall; a request moves on an edge where valid
// is high and stall is low. All cells compare against the broadcast value and
// shift left or right at the same edge, so a new request is taken every
// cycle while in_stall is low, and its result shows in the next cycle.
// The equality hit chain is a combinational path that runs across the row.
// A result waits in the output register while the receiver stalls; in that
// time in_stall is high and no new request is taken.
// Reset empties the list and drops any pending result at once; no clearing
// pass is needed since only the valid bits and the count are reset.
module sorted_list_insert_remove import slri_pkg::*; #(
  parameter int CAPACITY = SLRI_CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      action,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      ok,
  output logic [COUNT_W-1:0]        count,
  output logic                      is_empty
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Neighbor links. Index 0 stands for the left edge of the row and index
  // CAPACITY+1 for the right edge; cell i sits at index i+1.
  logic                      lt_chain    [0:CAPACITY];
  logic                      valid_chain [0:CAPACITY+1];
  logic signed [VALUE_W-1:0] val_chain   [0:CAPACITY+1];
  logic                      hit_chain   [0:CAPACITY];

  logic             accept;
  logic             full;
  logic             found;
  logic             op_ok;
  slri_op_t         op;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  // The left edge behaves as an endless run of smaller, valid entries; the
  // right edge as an empty slot.
  assign lt_chain[0]             = 1'b1;
  assign valid_chain[0]          = 1'b1;
  assign val_chain[0]            = '0;
  assign valid_chain[CAPACITY+1] = 1'b0;
  assign val_chain[CAPACITY+1]   = '0;
  assign hit_chain[0]            = 1'b0;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign full  = valid_chain[CAPACITY];
  assign found = hit_chain[CAPACITY];

  // An insert into a full list must leave every cell alone. A remove needs
  // no gating: with no hit, no cell moves.
  assign op.ins_en = accept && (action == ACT_INSERT) && !full;
  assign op.rem_en = accept && (action == ACT_REMOVE);
  assign op.value  = value;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      slri_cell u_cell (
        .clk          (clk),
        .rst          (rst),
        .op           (op),
        .left_lt      (lt_chain[i]),
        .left_valid   (valid_chain[i]),
        .left_val     (val_chain[i]),
        .right_valid  (valid_chain[i+2]),
        .right_val    (val_chain[i+2]),
        .hit_in       (hit_chain[i]),
        .lt           (lt_chain[i+1]),
        .stored_valid (valid_chain[i+1]),
        .stored_val   (val_chain[i+1]),
        .hit_out      (hit_chain[i+1])
      );
    end
  endgenerate

  // Outcome of the current request and the resulting fill level.
  always_comb begin
    op_ok    = 1'b0;
    cnt_next = cnt;
    case (action)
      ACT_INSERT: begin
        op_ok = !full;
        if (!full) begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      ACT_REMOVE: begin
        op_ok = found;
        if (found) begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      default: begin
        op_ok    = 1'b0;
        cnt_next = cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= cnt_next;
    end
  end

  // Output register: holds a result while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok       <= op_ok;
      count    <= COUNT_W'(cnt_next);
      is_empty <= (cnt_next == '0);
    end
  end

endmodule

// ----- hdl/slri_checker.sv -----
// Port-level checker for the sorted list block and its bind statement.
`include "sorted_list_insert_remove_defines.svh"

module slri_checker import slri_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      ok,
  input logic [COUNT_W-1:0]        count,
  input logic                      is_empty
);

  // The input is held back only by a result that cannot leave.
  `SLRI_ASSERT_NOW(a_stall_cause, clk, rst, in_stall, out_valid && out_stall, "in_stall without a stalled result")

  // Every accepted request shows a result in the following cycle.
  `SLRI_ASSERT_NEXT(a_result_follows, clk, rst, in_valid && !in_stall, out_valid, "accepted request gave no result")

  // An empty list always reports a zero count.
  `SLRI_ASSERT_NOW(a_empty_count, clk, rst, out_valid && is_empty, count == '0, "empty flag with nonzero count")

  // A stalled result keeps all of its fields.
  `SLRI_ASSERT_NEXT(a_hold_result, clk, rst, out_valid && out_stall, out_valid && $stable(ok) && $stable(count) && $stable(is_empty), "stalled result changed")

endmodule

bind sorted_list_insert_remove slri_checker u_slri_checker (.*);
